FILE: rtl/pfwt_pkg.sv
// Package: payload types, command codes and sizing constants for the fault window table.
package pfwt_pkg;

  localparam int unsigned MaxEntries = 16;
  localparam int unsigned DefEntries = 16;

  typedef enum logic [2:0] {
    CMD_ACTIVATE = 3'd0,
    CMD_WINDOW   = 3'd1,
    CMD_TICK     = 3'd2,
    CMD_QUERY    = 3'd3,
    CMD_CLEAR    = 3'd4
  } cmd_e;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [15:0] fault_index;
    logic [15:0] module_id;
    logic [7:0]  fault_kind;
    logic [31:0] duration_ms;
    logic [31:0] start_ms;
    logic [31:0] end_ms;
    logic [31:0] period_ms;
    logic [31:0] now_ms;
  } in_item_t;

  typedef struct packed {
    logic        status;
    logic        query_hit;
    logic [15:0] active_mask;
    logic [15:0] running_mask;
  } out_item_t;

  // Divider handshake between the sequencer and the shared divide unit.
  typedef struct packed {
    logic        start;
    logic [31:0] dividend;
    logic [31:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] remainder;
  } div_rsp_t;

endpackage

FILE: rtl/pfwt_div.sv
// Shared restoring divider: one quotient bit per cycle, returns the remainder.
module pfwt_div
  import pfwt_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic [31:0] rem_q, rem_d, num_q, num_d, den_q;
  logic [5:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d, done_q, done_d;
  logic [32:0] trial;

  assign trial = {rem_q, num_q[31]} - {1'b0, den_q};

  // Shift in one dividend bit and subtract when it fits
  always_comb begin
    rem_d  = rem_q;
    num_d  = num_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (req_i.start) begin
      rem_d  = '0;
      num_d  = req_i.dividend;
      cnt_d  = 6'd32;
      busy_d = 1'b1;
    end else if (busy_q) begin
      num_d = {num_q[30:0], 1'b0};
      if (!trial[32]) rem_d = trial[31:0];
      else rem_d = {rem_q[30:0], num_q[31]};
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == 6'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    num_q <= num_d;
    if (req_i.start) den_q <= req_i.divisor;
  end

  assign rsp_o.done      = done_q;
  assign rsp_o.remainder = rem_q;

endmodule

FILE: rtl/periodic_fault_window_table_top.sv
// Top level: fault window table with a sequencer walking the entries.
//
// Input channel in_valid_i/in_ready_o carries one command (in_item_i).
// Output channel out_valid_o/out_ready_i returns exactly one result per
// command: status, query hit and the active/running masks after it.
// Activate, set_window, query and unused codes go straight to a result.
// Clear walks the entries, one per cycle.
// Tick walks the entries one per cycle; a live entry inside its window with
// a nonzero period uses the shared divider to catch its cycle start up to
// now, and the walk holds on that entry until the divider is done.
// The divider and the single per-entry compare path serve every entry in turn.
// The block takes one command at a time; in_ready_o is low from the accept
// until the result is transferred. While the receiver stalls, the result
// holds on out_item_o. Reset clears every entry to zero (kind none) and
// leaves the block idle with no result pending.
module periodic_fault_window_table_top
  import pfwt_pkg::*;
#(
  parameter int unsigned ENTRIES = DefEntries
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_item_o
);

  localparam int unsigned IdxW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  typedef enum logic [2:0] {
    ST_IDLE, ST_EXEC, ST_WALK, ST_DIV, ST_FIN, ST_OUT
  } state_e;

  state_e state_q;
  in_item_t cmd_q;
  logic [IdxW-1:0] ptr_q;

  logic [ENTRIES-1:0] act_q, run_q;
  logic [15:0] mod_q [ENTRIES];
  logic [7:0]  kind_q [ENTRIES];
  logic [31:0] dur_q [ENTRIES];
  logic [31:0] wst_q [ENTRIES];
  logic [31:0] wen_q [ENTRIES];
  logic [31:0] per_q [ENTRIES];
  logic [31:0] cyc_q [ENTRIES];

  logic status_q, hit_q;

  div_req_t div_req;
  div_rsp_t div_rsp;

  pfwt_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // Shared per-entry path for the walked entry
  logic        bad;
  logic [IdxW-1:0] idx;
  logic [31:0] now, cur_cyc, seed, new_cyc;
  logic        in_win, last;

  assign bad = 32'(cmd_q.fault_index) >= 32'(ENTRIES);
  assign idx = cmd_q.fault_index[IdxW-1:0];
  assign now = cmd_q.now_ms;
  assign cur_cyc = cyc_q[ptr_q];
  assign in_win = !(now < wst_q[ptr_q]) && (now < wen_q[ptr_q]);
  assign seed = (cur_cyc == '0) ? wst_q[ptr_q] : cur_cyc;
  assign last = 32'(ptr_q) == 32'(ENTRIES - 1);
  // cycle_start + floor((now-cyc)/per)*per == now - remainder
  assign new_cyc = now - div_rsp.remainder;

  assign div_req.start    = (state_q == ST_WALK) && (cmd_q.cmd == CMD_TICK)
                            && (kind_q[ptr_q] != '0) && in_win
                            && (per_q[ptr_q] != '0) && !(now < seed);
  assign div_req.dividend = now - seed;
  assign div_req.divisor  = per_q[ptr_q];

  // Active test for a given cycle start
  function automatic logic act_of(logic [31:0] c, logic [31:0] n, logic [31:0] d);
    logic [31:0] s;
    s = c + d;
    return !(n < c) && (n < s);
  endfunction

  assign in_ready_o  = state_q == ST_IDLE;
  assign out_valid_o = state_q == ST_OUT;

  always_comb begin
    out_item_o              = '0;
    out_item_o.status       = status_q;
    out_item_o.query_hit    = hit_q;
    out_item_o.active_mask  = 16'(act_q);
    out_item_o.running_mask = 16'(run_q);
  end

  // Sequence commands, hold the table state and the result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      ptr_q    <= '0;
      act_q    <= '0;
      run_q    <= '0;
      status_q <= 1'b0;
      hit_q    <= 1'b0;
      for (int i = 0; i < ENTRIES; i++) begin
        mod_q[i]  <= '0;
        kind_q[i] <= '0;
        dur_q[i]  <= '0;
        wst_q[i]  <= '0;
        wen_q[i]  <= '0;
        per_q[i]  <= '0;
        cyc_q[i]  <= '0;
      end
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            state_q <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          ptr_q <= '0;
          unique case (cmd_q.cmd) inside
            CMD_ACTIVATE, CMD_WINDOW, CMD_QUERY: begin
              state_q  <= ST_OUT;
              status_q <= bad;
              hit_q    <= !bad && (cmd_q.cmd == CMD_QUERY)
                          && (mod_q[idx] == cmd_q.module_id) && act_q[idx];
              if (!bad && cmd_q.cmd == CMD_ACTIVATE) begin
                mod_q[idx]  <= cmd_q.module_id;
                kind_q[idx] <= cmd_q.fault_kind;
                dur_q[idx]  <= cmd_q.duration_ms;
                act_q[idx]  <= 1'b0;
                run_q[idx]  <= 1'b0;
                cyc_q[idx]  <= '0;
              end else if (!bad && cmd_q.cmd == CMD_WINDOW) begin
                wst_q[idx] <= cmd_q.start_ms;
                wen_q[idx] <= cmd_q.end_ms;
                per_q[idx] <= cmd_q.period_ms;
              end
            end
            CMD_TICK, CMD_CLEAR: begin
              state_q  <= ST_WALK;
              status_q <= 1'b0;
              hit_q    <= 1'b0;
            end
            default: begin
              state_q  <= ST_OUT;
              status_q <= 1'b0;
              hit_q    <= 1'b0;
            end
          endcase
        end
        ST_WALK: begin
          // Hold the pointer while the divider catches this entry up
          if (div_req.start) begin
            state_q <= ST_DIV;
          end else begin
            state_q <= last ? ST_OUT : ST_WALK;
            ptr_q   <= ptr_q + IdxW'(1);
          end
          if (cmd_q.cmd == CMD_CLEAR) begin
            if (mod_q[ptr_q] == cmd_q.module_id) begin
              kind_q[ptr_q] <= '0;
              act_q[ptr_q]  <= 1'b0;
              run_q[ptr_q]  <= 1'b0;
            end
          end else if (kind_q[ptr_q] != '0) begin
            if (!in_win) begin
              act_q[ptr_q] <= 1'b0;
              run_q[ptr_q] <= 1'b0;
            end else begin
              run_q[ptr_q] <= 1'b1;
              cyc_q[ptr_q] <= seed;
              if (!div_req.start) act_q[ptr_q] <= act_of(seed, now, dur_q[ptr_q]);
            end
          end
        end
        ST_DIV: begin
          if (div_rsp.done) begin
            cyc_q[ptr_q] <= new_cyc;
            act_q[ptr_q] <= act_of(new_cyc, now, dur_q[ptr_q]);
            state_q      <= ST_FIN;
          end
        end
        ST_FIN: begin
          ptr_q   <= ptr_q + IdxW'(1);
          state_q <= last ? ST_OUT : ST_WALK;
        end
        ST_OUT: begin
          if (out_ready_i) state_q <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // Capture the command on transfer
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) cmd_q <= in_item_i;
  end

endmodule
